// File: sv/sbbl_pkg.sv
package sbbl_pkg;

  // default and field widths
  localparam int unsigned DefaultAddrWidth = 32;
  localparam int unsigned ByteWidth        = 8;
  localparam int unsigned WordWidth        = 16;
  localparam int unsigned OutAddrWidth     = 32;

  // stream parser state, one-hot
  typedef enum logic [7:0] {
    ST_CNT_LO = 8'b0000_0001,
    ST_CNT_HI = 8'b0000_0010,
    ST_ADR_B2 = 8'b0000_0100,
    ST_ADR_B3 = 8'b0000_1000,
    ST_ADR_B4 = 8'b0001_0000,
    ST_ADR_B5 = 8'b0010_0000,
    ST_DATA   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } parse_state_e;

  // one result item
  typedef struct packed {
    logic                    write_valid;
    logic [OutAddrWidth-1:0] write_address;
    logic [WordWidth-1:0]    write_data;
    logic                    block_ack;
    logic                    finished;
    logic [OutAddrWidth-1:0] entry_address;
  } result_t;

endpackage

// File: sv/sbbl_parser.sv
module sbbl_parser #(
  parameter int unsigned ADDR_WIDTH = sbbl_pkg::DefaultAddrWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               take_i,
  input  logic [sbbl_pkg::ByteWidth-1:0]     rx_byte_i,
  output logic                               res_valid_o,
  output sbbl_pkg::result_t                  res_o
);

  sbbl_pkg::parse_state_e state_q, state_d;
  logic [sbbl_pkg::ByteWidth-1:0] cnt_lo_q, cnt_lo_d;
  logic [sbbl_pkg::WordWidth-1:0] words_left_q, words_left_d;
  logic [sbbl_pkg::WordWidth-1:0] words_dec;
  logic [sbbl_pkg::WordWidth-1:0] adr_hi_q, adr_hi_d;
  logic [sbbl_pkg::ByteWidth-1:0] adr_lo_q, adr_lo_d;
  logic [ADDR_WIDTH-1:0]          addr_q, addr_d;
  logic [ADDR_WIDTH-1:0]          start_q, start_d;
  logic [ADDR_WIDTH-1:0]          hdr_addr;
  logic [sbbl_pkg::ByteWidth-1:0] held_q, held_d;
  logic                           have_low_q, have_low_d;
  logic                           seen_q, seen_d;
  logic [31:0]                    addr_full;

  // full header address, bytes B3:B2:B5:B4 from high to low
  assign addr_full = {adr_hi_q, rx_byte_i, adr_lo_q};
  assign hdr_addr  = addr_full[ADDR_WIDTH-1:0];
  assign words_dec = words_left_q - 1'b1;

  // byte decode and result build
  always_comb begin
    state_d      = state_q;
    cnt_lo_d     = cnt_lo_q;
    words_left_d = words_left_q;
    adr_hi_d     = adr_hi_q;
    adr_lo_d     = adr_lo_q;
    addr_d       = addr_q;
    start_d      = start_q;
    held_d       = held_q;
    have_low_d   = have_low_q;
    seen_d       = seen_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (take_i) begin
      case (state_q)
        sbbl_pkg::ST_CNT_LO: begin
          cnt_lo_d = rx_byte_i;
          state_d  = sbbl_pkg::ST_CNT_HI;
        end
        sbbl_pkg::ST_CNT_HI: begin
          words_left_d = {rx_byte_i, cnt_lo_q};
          state_d      = sbbl_pkg::ST_ADR_B2;
        end
        sbbl_pkg::ST_ADR_B2: begin
          adr_hi_d[7:0] = rx_byte_i;
          state_d       = sbbl_pkg::ST_ADR_B3;
        end
        sbbl_pkg::ST_ADR_B3: begin
          adr_hi_d[15:8] = rx_byte_i;
          state_d        = sbbl_pkg::ST_ADR_B4;
        end
        sbbl_pkg::ST_ADR_B4: begin
          adr_lo_d = rx_byte_i;
          state_d  = sbbl_pkg::ST_ADR_B5;
        end
        sbbl_pkg::ST_ADR_B5: begin
          addr_d = hdr_addr;
          // first block address becomes the entry point
          if (!seen_q) begin
            seen_d  = 1'b1;
            start_d = hdr_addr;
          end
          if (words_left_q == '0) begin
            // terminating block
            state_d             = sbbl_pkg::ST_DONE;
            res_valid_o         = 1'b1;
            res_o.block_ack     = 1'b1;
            res_o.finished      = 1'b1;
            res_o.entry_address = seen_q ? sbbl_pkg::OutAddrWidth'(start_q)
                                         : sbbl_pkg::OutAddrWidth'(hdr_addr);
          end else begin
            have_low_d = 1'b0;
            state_d    = sbbl_pkg::ST_DATA;
          end
        end
        sbbl_pkg::ST_DATA: begin
          if (!have_low_q) begin
            held_d     = rx_byte_i;
            have_low_d = 1'b1;
          end else begin
            have_low_d          = 1'b0;
            addr_d              = addr_q + 1'b1;
            words_left_d        = words_dec;
            res_valid_o         = 1'b1;
            res_o.write_valid   = 1'b1;
            res_o.write_address = sbbl_pkg::OutAddrWidth'(addr_q);
            res_o.write_data    = {rx_byte_i, held_q};
            if (words_dec == '0) begin
              res_o.block_ack = 1'b1;
              state_d         = sbbl_pkg::ST_CNT_LO;
            end
          end
        end
        sbbl_pkg::ST_DONE: begin
          state_d = sbbl_pkg::ST_DONE;
        end
        default: begin
          state_d = sbbl_pkg::ST_CNT_LO;
        end
      endcase
    end
  end

  // stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sbbl_pkg::ST_CNT_LO;
      cnt_lo_q     <= '0;
      words_left_q <= '0;
      adr_hi_q     <= '0;
      adr_lo_q     <= '0;
      addr_q       <= '0;
      start_q      <= '0;
      held_q       <= '0;
      have_low_q   <= 1'b0;
      seen_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_lo_q     <= cnt_lo_d;
      words_left_q <= words_left_d;
      adr_hi_q     <= adr_hi_d;
      adr_lo_q     <= adr_lo_d;
      addr_q       <= addr_d;
      start_q      <= start_d;
      held_q       <= held_d;
      have_low_q   <= have_low_d;
      seen_q       <= seen_d;
    end
  end

endmodule

// File: sv/sbbl_out_buf.sv
module sbbl_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sbbl_pkg::result_t push_data_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sbbl_pkg::result_t out_data_o
);

  sbbl_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic              out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic              pop;

  assign pop         = out_vld_q & out_ready_i;
  assign space_o     = ~skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // output register with one skid entry behind it
  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_d     = push_data_i;
        skid_vld_d = push_i;
      end else begin
        out_d     = push_data_i;
        out_vld_d = push_i;
      end
    end else if (push_i) begin
      skid_d     = push_data_i;
      skid_vld_d = 1'b1;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// File: sv/serial_boot_block_loader.sv
// channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------
// in       | in_valid_i / in_ready_o    | rx_byte_i
// out      | out_valid_o / out_ready_i  | write_valid_o, write_address_o,
//          |                            | write_data_o, block_ack_o,
//          |                            | finished_o, entry_address_o
//
// one byte per cycle while in_ready_o is high: a byte is decoded in the cycle it is
// taken and its result, if any, is registered in the output register or skid entry.
// reset puts the parser at the first header byte with no entry point seen.
// an output register plus one skid entry let input keep flowing for one
// result while the output stalls; in_ready_o drops only when both are full.
// bytes after the terminating block are taken and dropped.
module serial_boot_block_loader #(
  parameter int unsigned ADDR_WIDTH = sbbl_pkg::DefaultAddrWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sbbl_pkg::ByteWidth-1:0]      rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                write_valid_o,
  output logic [sbbl_pkg::OutAddrWidth-1:0]   write_address_o,
  output logic [sbbl_pkg::WordWidth-1:0]      write_data_o,
  output logic                                block_ack_o,
  output logic                                finished_o,
  output logic [sbbl_pkg::OutAddrWidth-1:0]   entry_address_o
);

  logic              take;
  logic              space;
  logic              res_valid;
  sbbl_pkg::result_t res;
  sbbl_pkg::result_t out_data;

  assign in_ready_o = space;
  assign take       = in_valid_i & space;

  // byte decode
  sbbl_parser #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result buffering
  sbbl_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign write_valid_o   = out_data.write_valid;
  assign write_address_o = out_data.write_address;
  assign write_data_o    = out_data.write_data;
  assign block_ack_o     = out_data.block_ack;
  assign finished_o      = out_data.finished;
  assign entry_address_o = out_data.entry_address;

endmodule
